>>> hw/rtl/mf3_pkg.sv
`default_nettype none

package mf3_pkg;

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // smallest frame dimension accepted
    localparam int MIN_DIM = 3;

    // number of result slots per pixel
    localparam int NUM_SLOTS = 4;

    // per-pixel control that travels down the pipe
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;  // slots (r-1,c-1) (r-1,c) (r,c-1) (r,c)
        logic                 top;   // upper result row is frame row 0
        logic                 left;  // left result column is frame column 0
    } item_flags_t;

    function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = min8(a, b);
        hi = max8(a, b);
        return min8(max8(c, lo), hi);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mf3_ram.sv
`default_nettype none

module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/median_filter_3x3_u8_top.sv
// Pipeline: an accepted pixel passes the s1, s2, s3 and s4 stages before its first result
//   reaches the output registers; a pixel with several results holds its s4 slot until all are taken.
// Throughput: one pixel per cycle while each pixel yields at most one result and the receiver
//   does not stall; the single output register drains the result slots one transfer per cycle while out_ready holds.
// Reset: geometry returns to 320x240, position to row 0 column 0, window to zero;
//   line store contents stay undefined until written.
`default_nettype none

module median_filter_3x3_u8_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_index,
    input  wire logic [(($clog2(MAX_WIDTH+1) > $clog2(MAX_HEIGHT+1)) ?
                        $clog2(MAX_WIDTH+1) : $clog2(MAX_HEIGHT+1))-1:0] cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [7:0]                           pixel,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic      [$clog2(MAX_HEIGHT)-1:0]        out_row,
    output logic      [$clog2(MAX_WIDTH)-1:0]         out_col,
    output logic      [7:0]                           median_value,
    output logic                                      run_last,
    output logic                                      frame_done
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int FW_W  = $clog2(MAX_WIDTH + 1);
    localparam int FH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int NS    = mf3_pkg::NUM_SLOTS;

    // geometry and position
    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    logic             in_xfer;
    logic             adv;
    logic [FW_W-1:0]  col_plus;
    logic [FH_W-1:0]  row_plus;
    logic             col_wrap;
    logic             row_wrap;
    logic [FW_W-1:0]  cfg_w_val;
    logic [FH_W-1:0]  cfg_h_val;

    // pipe stages
    logic                  s1_valid_reg;
    logic [7:0]            s1_px_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    mf3_pkg::item_flags_t  s1_flags_reg;
    mf3_pkg::item_flags_t  s1_flags_next;

    logic                  s2_valid_reg;
    logic [COL_W-1:0]      s2_col_reg;
    logic [ROW_W-1:0]      s2_row_reg;
    mf3_pkg::item_flags_t  s2_flags_reg;

    logic                  s3_valid_reg;
    logic [COL_W-1:0]      s3_col_reg;
    logic [ROW_W-1:0]      s3_row_reg;
    mf3_pkg::item_flags_t  s3_flags_reg;
    logic [7:0]            s3_lo_reg  [3];
    logic [7:0]            s3_mid_reg [3];
    logic [7:0]            s3_hi_reg  [3];
    logic                  s3_full_reg;
    logic [7:0]            s3_v0_reg;
    logic [7:0]            s3_v1_reg;
    logic [7:0]            s3_v2_reg;
    logic [7:0]            s3_v3_reg;

    logic [NS-1:0]         s4_pend_reg;
    logic [COL_W-1:0]      s4_col_reg;
    logic [ROW_W-1:0]      s4_row_reg;
    logic [7:0]            s4_val_reg [NS];

    // window, oldest row first, newest column last
    logic [7:0]            win_reg [9];

    // line store: {older row, newer row}
    logic [15:0]           ls_rdata;

    // output register
    logic                  out_valid_reg;
    logic [ROW_W-1:0]      out_row_reg;
    logic [COL_W-1:0]      out_col_reg;
    logic [7:0]            median_value_reg;
    logic                  run_last_reg;
    logic                  frame_done_reg;

    logic                  out_free;
    logic                  take;
    logic [1:0]            sel;
    logic [NS-1:0]         pend_after;
    logic [7:0]            med9;

    // handshake and stage advance
    assign out_free = !out_valid_reg || out_ready;
    assign take     = (s4_pend_reg != '0) && out_free;
    assign adv      = (s4_pend_reg == '0) || (take && (pend_after == '0));
    assign in_ready = adv;
    assign in_xfer  = in_valid && adv;

    // position arithmetic
    assign col_plus = FW_W'(col_reg) + FW_W'(1);
    assign row_plus = FH_W'(row_reg) + FH_W'(1);
    assign col_wrap = (col_plus >= width_reg);
    assign row_wrap = (row_plus >= height_reg);

    // result slots caused by this pixel
    always_comb
    begin
        s1_flags_next.mask[0] = (row_reg != '0) && (col_reg != '0);
        s1_flags_next.mask[1] = (row_reg != '0) && col_wrap;
        s1_flags_next.mask[2] = row_wrap && (col_reg != '0);
        s1_flags_next.mask[3] = row_wrap && col_wrap;
        s1_flags_next.top     = (row_reg == ROW_W'(1));
        s1_flags_next.left    = (col_reg == COL_W'(1));
    end

    // clamp of written geometry
    always_comb
    begin
        cfg_w_val = cfg_data[FW_W-1:0];
        cfg_h_val = cfg_data[FH_W-1:0];
        if (cfg_w_val < FW_W'(mf3_pkg::MIN_DIM))
        begin
            cfg_w_val = FW_W'(mf3_pkg::MIN_DIM);
        end
        else if (cfg_w_val > FW_W'(MAX_WIDTH))
        begin
            cfg_w_val = FW_W'(MAX_WIDTH);
        end
        if (cfg_h_val < FH_W'(mf3_pkg::MIN_DIM))
        begin
            cfg_h_val = FH_W'(mf3_pkg::MIN_DIM);
        end
        else if (cfg_h_val > FH_W'(MAX_HEIGHT))
        begin
            cfg_h_val = FH_W'(MAX_HEIGHT);
        end
    end

    // geometry registers and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FW_W'(320);
            height_reg <= FH_W'(240);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mf3_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_w_val;
                mf3_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_h_val;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_xfer)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_plus[ROW_W-1:0];
            end
            else
            begin
                col_reg <= col_plus[COL_W-1:0];
            end
        end
    end

    // line store, read at transfer, written back as the pixel leaves the first stage
    mf3_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (adv && s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata ({ls_rdata[7:0], s1_px_reg}),
        .re    (in_xfer),
        .raddr (col_reg),
        .rdata (ls_rdata)
    );

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_pend_reg  <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_xfer;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_pend_reg  <= s3_valid_reg ? s3_flags_reg.mask : '0;
        end
        else if (take)
        begin
            s4_pend_reg <= pend_after;
        end
    end

    // window shift as the pixel leaves the first stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (adv && s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i*3]   <= win_reg[i*3+1];
                win_reg[i*3+1] <= win_reg[i*3+2];
            end
            win_reg[2] <= ls_rdata[15:8];
            win_reg[5] <= ls_rdata[7:0];
            win_reg[8] <= s1_px_reg;
        end
    end

    // pipe payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_px_reg    <= pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_flags_reg <= s1_flags_next;

            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;
            s2_flags_reg <= s1_flags_reg;

            // column sorts and edge values from the window
            s3_col_reg   <= s2_col_reg;
            s3_row_reg   <= s2_row_reg;
            s3_flags_reg <= s2_flags_reg;
            for (int j = 0; j < 3; j++)
            begin
                s3_lo_reg[j]  <= mf3_pkg::min8(mf3_pkg::min8(win_reg[j], win_reg[3+j]),
                                               win_reg[6+j]);
                s3_mid_reg[j] <= mf3_pkg::med3(win_reg[j], win_reg[3+j], win_reg[6+j]);
                s3_hi_reg[j]  <= mf3_pkg::max8(mf3_pkg::max8(win_reg[j], win_reg[3+j]),
                                               win_reg[6+j]);
            end
            s3_full_reg <= !s2_flags_reg.top && !s2_flags_reg.left;
            priority if (s2_flags_reg.top && s2_flags_reg.left)
            begin
                s3_v0_reg <= win_reg[4];
            end
            else if (s2_flags_reg.top)
            begin
                s3_v0_reg <= mf3_pkg::med3(win_reg[3], win_reg[4], win_reg[5]);
            end
            else
            begin
                s3_v0_reg <= mf3_pkg::med3(win_reg[1], win_reg[4], win_reg[7]);
            end
            s3_v1_reg <= s2_flags_reg.top ? win_reg[5]
                       : mf3_pkg::med3(win_reg[2], win_reg[5], win_reg[8]);
            s3_v2_reg <= s2_flags_reg.left ? win_reg[7]
                       : mf3_pkg::med3(win_reg[6], win_reg[7], win_reg[8]);
            s3_v3_reg <= win_reg[8];

            // nine-point median finish and result slots
            s4_col_reg    <= s3_col_reg;
            s4_row_reg    <= s3_row_reg;
            s4_val_reg[0] <= s3_full_reg ? med9 : s3_v0_reg;
            s4_val_reg[1] <= s3_v1_reg;
            s4_val_reg[2] <= s3_v2_reg;
            s4_val_reg[3] <= s3_v3_reg;
        end
    end

    // median of nine from sorted columns
    assign med9 = mf3_pkg::med3(
        mf3_pkg::max8(mf3_pkg::max8(s3_lo_reg[0], s3_lo_reg[1]), s3_lo_reg[2]),
        mf3_pkg::med3(s3_mid_reg[0], s3_mid_reg[1], s3_mid_reg[2]),
        mf3_pkg::min8(mf3_pkg::min8(s3_hi_reg[0], s3_hi_reg[1]), s3_hi_reg[2]));

    // pick the first pending slot in raster order
    always_comb
    begin
        priority if (s4_pend_reg[0])
        begin
            sel = 2'd0;
        end
        else if (s4_pend_reg[1])
        begin
            sel = 2'd1;
        end
        else if (s4_pend_reg[2])
        begin
            sel = 2'd2;
        end
        else
        begin
            sel = 2'd3;
        end
        pend_after      = s4_pend_reg;
        pend_after[sel] = 1'b0;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= (s4_pend_reg != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_row_reg      <= sel[1] ? s4_row_reg : s4_row_reg - ROW_W'(1);
            out_col_reg      <= sel[0] ? s4_col_reg : s4_col_reg - COL_W'(1);
            median_value_reg <= s4_val_reg[sel];
            run_last_reg     <= (pend_after == '0);
            frame_done_reg   <= (sel == 2'd3);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign median_value = median_value_reg;
    assign run_last     = run_last_reg;
    assign frame_done   = frame_done_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mf3_checker.sv
`default_nettype none

module mf3_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [$clog2(MAX_HEIGHT)-1:0] out_row,
    input wire logic [$clog2(MAX_WIDTH)-1:0]  out_col,
    input wire logic [7:0]                    median_value,
    input wire logic                          run_last,
    input wire logic                          frame_done
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(median_value)
            && $stable(out_row) && $stable(out_col))
        else $error("stalled result changed");

    // the frame's final result ends its pixel's run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> run_last)
        else $error("frame end without run end");

    // the frame's final result is never on row or column zero
    a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> (out_row != '0) && (out_col != '0))
        else $error("frame end at bad position");

    // nothing shows right after reset release
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present after reset");

endmodule

bind median_filter_3x3_u8_top mf3_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
) u_mf3_checker (.*);

`default_nettype wire

>>> sim/median_filter_3x3_u8_checker.sv
`timescale 1ns / 100ps

module median_filter_3x3_u8_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  pixel,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [11:0] out_row,
    input  logic [9:0]  out_col,
    input  logic [7:0]  median_value,
    input  logic        run_last,
    input  logic        frame_done,
    output int          errors,
    output int          pending
);

    typedef struct {
        bit [11:0] row;
        bit [9:0]  col;
        bit [7:0]  value;
        bit        last;
        bit        done;
    } filtered_px_t;

    // predictor state
    int unsigned frame_w;
    int unsigned frame_h;
    int unsigned col_pos;
    int unsigned row_pos;
    bit [7:0] row_older [1024];
    bit [7:0] row_newer [1024];
    bit [7:0] win [9];
    filtered_px_t filtered_q [$];

    function automatic bit [7:0] mid_of_three(bit [7:0] a, bit [7:0] b, bit [7:0] c);
        bit [7:0] lo;
        bit [7:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) return lo;
        if (c >= hi) return hi;
        return c;
    endfunction

    function automatic bit [7:0] mid_of_nine();
        bit [7:0] s [9];
        bit [7:0] t;
        for (int i = 0; i < 9; i++) s[i] = win[i];
        // plain bubble sort, nine entries
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8 - i; j++)
                if (s[j] > s[j+1])
                begin
                    t = s[j];
                    s[j] = s[j+1];
                    s[j+1] = t;
                end
        return s[4];
    endfunction

    function automatic bit [7:0] filter_px(int unsigned orow, int unsigned ocol,
                                           int ri, int ci);
        bit er;
        bit ec;
        er = (orow == 0) || (orow == frame_h - 1);
        ec = (ocol == 0) || (ocol == frame_w - 1);
        if (er && ec) return win[ri*3+ci];
        if (er) return mid_of_three(win[ri*3+ci-1], win[ri*3+ci], win[ri*3+ci+1]);
        if (ec) return mid_of_three(win[(ri-1)*3+ci], win[ri*3+ci], win[(ri+1)*3+ci]);
        return mid_of_nine();
    endfunction

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    // shift window, update line stores, queue the results this pixel releases
    task automatic take_pixel(input bit [7:0] p);
        int unsigned c;
        int unsigned r;
        int unsigned orow;
        int unsigned ocol;
        int n;
        filtered_px_t e;
        c = col_pos;
        r = row_pos;
        n = 0;
        for (int i = 0; i < 3; i++)
        begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = row_older[c];
        win[5] = row_newer[c];
        win[8] = p;
        row_older[c] = row_newer[c];
        row_newer[c] = p;
        for (int rs = 0; rs < 2; rs++)
        begin
            if (rs == 0 && r < 1) continue;
            if (rs == 1 && r != frame_h - 1) continue;
            orow = (rs == 0) ? r - 1 : r;
            for (int cs = 0; cs < 2; cs++)
            begin
                if (cs == 0 && c < 1) continue;
                if (cs == 1 && c != frame_w - 1) continue;
                ocol = (cs == 0) ? c - 1 : c;
                e.row   = orow[11:0];
                e.col   = ocol[9:0];
                e.value = filter_px(orow, ocol, rs + 1, cs + 1);
                e.last  = 1'b0;
                e.done  = (orow == frame_h - 1) && (ocol == frame_w - 1);
                filtered_q.push_back(e);
                n++;
            end
        end
        if (n > 0) filtered_q[filtered_q.size()-1].last = 1'b1;
        if (c + 1 >= frame_w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= frame_h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    // compare one result transfer against the oldest expectation
    task automatic check_result();
        filtered_px_t e;
        if (filtered_q.size() == 0)
        begin
            if (errors < 10)
                $display("unexpected result row %0d col %0d value %0d",
                         out_row, out_col, median_value);
            errors++;
            return;
        end
        e = filtered_q.pop_front();
        if (out_row !== e.row || out_col !== e.col || median_value !== e.value ||
            run_last !== e.last || frame_done !== e.done)
        begin
            if (errors < 10)
                $display("mismatch: exp r%0d c%0d v%0d l%0d d%0d got r%0d c%0d v%0d l%0d d%0d",
                         e.row, e.col, e.value, e.last, e.done,
                         out_row, out_col, median_value, run_last, frame_done);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w = 320;
            frame_h = 240;
            col_pos = 0;
            row_pos = 0;
            for (int i = 0; i < 9; i++) win[i] = 8'd0;
            for (int i = 0; i < 1024; i++)
            begin
                row_older[i] = 8'd0;
                row_newer[i] = 8'd0;
            end
            filtered_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            // geometry writes restart the frame position
            if (cfg_we)
            begin
                if (cfg_index == mf3_pkg::REG_FRAME_WIDTH)
                    frame_w = clamp_dim(cfg_data[10:0], 1024);
                else
                    frame_h = clamp_dim(cfg_data, 4096);
                col_pos = 0;
                row_pos = 0;
            end
            if (in_valid && in_ready) take_pixel(pixel);
            if (out_valid && out_ready) check_result();
            pending = filtered_q.size();
        end
    end

endmodule

>>> sim/median_filter_3x3_u8_top_test.sv
`timescale 1ns / 100ps

module median_filter_3x3_u8_top_test;

    localparam int STALL_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  pixel;
    logic        out_valid;
    logic        out_ready;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic [7:0]  median_value;
    logic        run_last;
    logic        frame_done;
    int          errors;
    int          pending;
    bit          idle_on;
    int          quiet_cycles = 0;
    int          pixel_mode;

    median_filter_3x3_u8_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_row(out_row), .out_col(out_col), .median_value(median_value),
        .run_last(run_last), .frame_done(frame_done)
    );

    median_filter_3x3_u8_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_row(out_row), .out_col(out_col), .median_value(median_value),
        .run_last(run_last), .frame_done(frame_done),
        .errors(errors), .pending(pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver stalls
    always @(posedge clk)
        out_ready <= idle_on ? ($urandom_range(0, 99) >= 32) : 1'b1;

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [12:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every result is out, then let the pipe settle
    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic push_pixel(input logic [7:0] p);
        while (idle_on && $urandom_range(0, 99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= p;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [7:0] rand_px();
        case (pixel_mode)
            0: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            1: return 8'(120 + $urandom_range(0, 8));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_pixels(input int n);
        for (int i = 0; i < n; i++) push_pixel(rand_px());
        in_valid <= 1'b0;
    endtask

    task automatic set_geometry(input logic [12:0] w, input logic [12:0] h);
        drain();
        write_reg(mf3_pkg::REG_FRAME_WIDTH, w);
        write_reg(mf3_pkg::REG_FRAME_HEIGHT, h);
    endtask

    initial
    begin
        logic [7:0] corner_frame [9];
        int sent;
        int w;
        int h;
        int n;
        corner_frame = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd1, 8'd254, 8'd127, 8'd64};
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = mf3_pkg::REG_FRAME_WIDTH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        pixel        = 8'd0;
        idle_on      = 1'b1;
        pixel_mode   = 2;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame with extreme pixels, written below the minimum
        write_reg(mf3_pkg::REG_FRAME_WIDTH, 13'd0);
        write_reg(mf3_pkg::REG_FRAME_HEIGHT, 13'd2);
        for (int i = 0; i < 9; i++) push_pixel(corner_frame[i]);
        for (int i = 0; i < 9; i++) push_pixel(8'hFF);
        in_valid <= 1'b0;

        // random geometries, mostly whole frames
        sent = 18;
        while (sent < 280)
        begin
            idle_on    = ($urandom_range(0, 5) != 0);
            pixel_mode = $urandom_range(0, 5);
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            case ($urandom_range(0, 9))
                0: set_geometry(13'($urandom_range(0, 2)), 13'(h));
                1: set_geometry(13'(w), 13'($urandom_range(0, 2)));
                2: set_geometry(13'(w), 13'(h));
                default: set_geometry(13'(w), 13'(h));
            endcase
            w = (w < 3) ? 3 : w;
            case ($urandom_range(0, 4))
                0: n = $urandom_range(1, w * h - 1);
                1: n = 2 * w * h;
                default: n = w * h;
            endcase
            if (cfg_data < 3) n = (n > 40) ? 40 : n;
            send_pixels(n);
            sent += n;
        end

        // out-of-range writes clamp to the maximum, stopped early
        idle_on = 1'b1;
        set_geometry(13'd2047, 13'd8191);
        send_pixels(50);

        // narrow frame with clamped height, many rows with no bottom edge
        set_geometry(13'd3, 13'd8191);
        send_pixels(60);

        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
